[rtl/core/q8mv_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_pkg
// Shared types, widths and constants for the Q8_0 block-quantised mat-vec core.
// ----------------------------------------------------------------------------
package q8mv_pkg;

  // defaults for the top-level parameters
  localparam int BLOCK_SIZE_DEF = 32;
  localparam int LANES_DEF      = 4;
  localparam int MAX_BLOCKS_DEF = 256;

  // field widths
  localparam int Q_W       = 8;
  localparam int ACT_W     = 16;
  localparam int SCALE_W   = 16;
  localparam int PROD_W    = Q_W + ACT_W;
  localparam int BSUM_W    = 32;
  localparam int MAG_W     = 28;              // |block sum| <= 32 * 128 * 32768 = 2^27
  localparam int MANT_W    = 11;              // half mantissa with hidden bit
  localparam int PSC_W     = MAG_W + MANT_W;  // magnitude times mantissa
  localparam int ACC_W     = 48;
  localparam int ROW_IDX_W = 16;
  localparam int BPR_W     = 9;
  localparam int ROWS_W    = 17;
  localparam int MAX_ROWS  = 65536;

  // half-float decoding
  localparam int            HALF_EXP_W  = 5;
  localparam int            HALF_FRAC_W = 10;
  localparam logic [4:0]    HALF_EXP_INF = 5'd31;
  localparam logic [4:0]    EXP_UNITY    = 5'd13;   // exponent at which no shift applies
  localparam int            MAX_LSHIFT   = 17;      // largest finite exponent minus 13
  localparam int            WIDE_W       = PSC_W + MAX_LSHIFT;

  localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCKS_PER_ROW = 8'd0,
    CFG_ROW_COUNT      = 8'd1
  } cfg_reg_t;

  localparam int OUT_TDATA_W = ACC_W + ROW_IDX_W;

  // control that travels alongside the data through the pipeline
  typedef struct packed {
    logic                 valid;
    logic                 blk_end;
    logic                 row_end;
    logic                 last;
    logic [ROW_IDX_W-1:0] row_index;
    logic [SCALE_W-1:0]   scale;
  } q8mv_tag_t;

endpackage

[rtl/core/q8mv_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_lane
// One multiply lane: signed 8-bit weight times Q4.12 activation, registered.
// ----------------------------------------------------------------------------
module q8mv_lane import q8mv_pkg::*; (
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [Q_W-1:0]    q_i,
  input  logic signed [ACT_W-1:0]  act_i,
  output logic signed [PROD_W-1:0] prod_r
);

  logic signed [PROD_W-1:0] prod_nxt;

  assign prod_nxt = PROD_W'(q_i) * PROD_W'(act_i);

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

[rtl/core/q8mv_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_merge
// Adds the lane products into the running block sum; hands the finished
// block sum on at the last lane group of each block.
// ----------------------------------------------------------------------------
module q8mv_merge import q8mv_pkg::*; #(
  parameter int LANES = LANES_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  q8mv_tag_t                tag_i,
  input  logic signed [PROD_W-1:0] prod_i [LANES],
  output q8mv_tag_t                tag_r,
  output logic signed [BSUM_W-1:0] bsum_r
);

  logic signed [BSUM_W-1:0] bacc_r;
  logic signed [BSUM_W-1:0] bacc_nxt;
  logic signed [BSUM_W-1:0] lane_sum;
  logic signed [BSUM_W-1:0] total;
  q8mv_tag_t                tag_nxt;

  always_comb begin
    lane_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      lane_sum = lane_sum + {{(BSUM_W-PROD_W){prod_i[i][PROD_W-1]}}, prod_i[i]};
    end
    total = bacc_r + lane_sum;

    bacc_nxt = bacc_r;
    if (tag_i.valid) begin
      bacc_nxt = tag_i.blk_end ? '0 : total;
    end

    // only block ends travel further down
    tag_nxt       = tag_i;
    tag_nxt.valid = tag_i.valid && tag_i.blk_end;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bacc_r <= '0;
      tag_r  <= '0;
    end else if (en) begin
      bacc_r <= bacc_nxt;
      tag_r  <= tag_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bsum_r <= total;
    end
  end

endmodule

[rtl/core/q8mv_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_scale
// Multiplies a block sum by its half-float scale: magnitude times mantissa,
// then a rounding right shift or a saturating left shift to 24 fraction bits.
// ----------------------------------------------------------------------------
module q8mv_scale import q8mv_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  q8mv_tag_t               tag_i,
  input  logic signed [BSUM_W-1:0] bsum_i,
  output q8mv_tag_t               tag_r,
  output logic [ACC_W-1:0]        term_r,
  output logic                    tsat_r
);

  // ---- stage A: magnitude times mantissa ----
  logic [BSUM_W-1:0]     abs_sum;
  logic [MAG_W-1:0]      mag;
  logic [HALF_EXP_W-1:0] exp_f;
  logic [MANT_W-1:0]     mant;
  logic [PSC_W-1:0]      p_nxt;
  logic                  neg_nxt;

  q8mv_tag_t             a_tag_r;
  logic [PSC_W-1:0]      a_p_r;
  logic                  a_neg_r;
  logic                  a_zero_r;
  logic [HALF_EXP_W-1:0] a_exp_r;

  always_comb begin
    abs_sum = bsum_i[BSUM_W-1] ? BSUM_W'(-bsum_i) : BSUM_W'(bsum_i);
    mag     = abs_sum[MAG_W-1:0];
    exp_f   = tag_i.scale[HALF_FRAC_W +: HALF_EXP_W];
    mant    = {(exp_f != '0), tag_i.scale[HALF_FRAC_W-1:0]};
    p_nxt   = PSC_W'(mag) * PSC_W'(mant);
    neg_nxt = bsum_i[BSUM_W-1] ^ tag_i.scale[SCALE_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_tag_r <= '0;
    end else if (en) begin
      a_tag_r <= tag_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_p_r    <= p_nxt;
      a_neg_r  <= neg_nxt;
      a_zero_r <= (mag == '0);
      a_exp_r  <= exp_f;
    end
  end

  // ---- stage B: shift to 24 fraction bits ----
  logic [HALF_EXP_W-1:0] e_eff;
  logic [3:0]            rsh;
  logic [HALF_EXP_W-1:0] lsh;
  logic [PSC_W:0]        half_ulp;
  logic [PSC_W:0]        rnd;
  logic [WIDE_W-1:0]     wide;
  logic [WIDE_W-1:0]     limit;
  logic [ACC_W-1:0]      mag_out;
  logic [ACC_W-1:0]      term_nxt;
  logic                  tsat_nxt;

  always_comb begin
    e_eff    = (a_exp_r == '0) ? HALF_EXP_W'(1) : a_exp_r;
    rsh      = 4'(EXP_UNITY - e_eff);
    lsh      = e_eff - EXP_UNITY;
    half_ulp = (PSC_W+1)'(1) << (rsh - 4'd1);
    rnd      = ({1'b0, a_p_r} + half_ulp) >> rsh;
    wide     = WIDE_W'(a_p_r) << lsh;
    limit    = a_neg_r ? WIDE_W'(ACC_MIN) : WIDE_W'(ACC_MAX);
    tsat_nxt = 1'b0;

    if (e_eff < EXP_UNITY) begin
      mag_out = ACC_W'(rnd);
    end else if (e_eff > EXP_UNITY) begin
      if (wide > limit) begin
        mag_out  = limit[ACC_W-1:0];
        tsat_nxt = 1'b1;
      end else begin
        mag_out = wide[ACC_W-1:0];
      end
    end else begin
      mag_out = ACC_W'(a_p_r);
    end
    term_nxt = a_neg_r ? ACC_W'(-mag_out) : mag_out;

    // Inf or NaN scale: clamp with the product's sign, zero sum stays zero
    if (a_exp_r == HALF_EXP_INF) begin
      tsat_nxt = 1'b1;
      term_nxt = a_zero_r ? '0 : (a_neg_r ? ACC_MIN : ACC_MAX);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_r <= '0;
    end else if (en) begin
      tag_r <= a_tag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      term_r <= term_nxt;
      tsat_r <= tsat_nxt;
    end
  end

endmodule

[rtl/core/q8_block_quantized_matvec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8_block_quantized_matvec
// Q8_0 block-quantised matrix-vector product: lanes of weight x activation,
// block sums scaled by a half-float, saturating row accumulation.
// ----------------------------------------------------------------------------
//  channel | direction | tdata fields (lsb first)                       | side
//  --------+-----------+------------------------------------------------+--------------
//  in_     | slave     | q_lane0..N-1, act_lane0..N-1, block_scale      | -
//  out_    | master    | row_sum[47:0], row_index[15:0]                 | tlast=last_row
//          |           |                                                | tuser=saturated
//  cfg_    | write     | index 0 blocks_per_row, index 1 row_count      | cfg_ready tied
//
//  One item is taken per cycle while in_tready is high; the four lane multipliers
//  and the merge adder set that rate. A row result passes the lane, merge,
//  scale A, scale B and output registers before it is offered on out_.
//  Reset is synchronous; control state is cleared at once, data registers are not.
//  in_tready drops only while a row result is stuck behind an untaken output.
// ----------------------------------------------------------------------------
module q8_block_quantized_matvec import q8mv_pkg::*; #(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
  parameter int LANES      = LANES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  localparam int IN_TDATA_W = ((LANES * (Q_W + ACT_W) + SCALE_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // q_lane0..N-1, act_lane0..N-1, block_scale, zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // row_sum, row_index
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  // saturated
  output logic                   out_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int GROUPS    = BLOCK_SIZE / LANES;
  localparam int GRP_W     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int BLK_W     = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CMP_W     = ($clog2(MAX_BLOCKS + 1) > BPR_W) ? $clog2(MAX_BLOCKS + 1) : BPR_W;
  localparam int SCALE_LSB = LANES * (Q_W + ACT_W);

  // ---------------- configuration ----------------
  logic [BPR_W-1:0]  bpr_cfg_r;
  logic [ROWS_W-1:0] rows_cfg_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpr_cfg_r  <= BPR_W'(1);
      rows_cfg_r <= ROWS_W'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_BLOCKS_PER_ROW: bpr_cfg_r  <= cfg_data[BPR_W-1:0];
        CFG_ROW_COUNT:      rows_cfg_r <= cfg_data[ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- front counters ----------------
  logic                 adv;
  logic                 in_xfer;
  logic [GRP_W-1:0]     grp_r, grp_nxt;
  logic [BLK_W-1:0]     blk_r, blk_nxt;
  logic [ROW_IDX_W-1:0] row_r, row_nxt;
  logic [SCALE_W-1:0]   scale_r, scale_nxt;
  logic [SCALE_W-1:0]   in_scale;
  logic [CMP_W-1:0]     bpr_ext, bpr_eff;
  logic [ROWS_W-1:0]    rows_eff;
  logic                 blk_end, row_done, last_row;
  q8mv_tag_t            tag0_nxt, tag0_r;

  assign in_tready = adv;
  assign in_xfer   = in_tvalid && in_tready;
  assign in_scale  = in_tdata[SCALE_LSB +: SCALE_W];

  always_comb begin
    bpr_ext = CMP_W'(bpr_cfg_r);
    if (bpr_ext == '0) begin
      bpr_eff = CMP_W'(1);
    end else if (bpr_ext > CMP_W'(MAX_BLOCKS)) begin
      bpr_eff = CMP_W'(MAX_BLOCKS);
    end else begin
      bpr_eff = bpr_ext;
    end

    if (rows_cfg_r == '0) begin
      rows_eff = ROWS_W'(1);
    end else if (rows_cfg_r > ROWS_W'(MAX_ROWS)) begin
      rows_eff = ROWS_W'(MAX_ROWS);
    end else begin
      rows_eff = rows_cfg_r;
    end

    blk_end  = ({1'b0, grp_r} + (GRP_W+1)'(1)) >= (GRP_W+1)'(GROUPS);
    row_done = (CMP_W'(blk_r) + CMP_W'(1)) >= bpr_eff;
    last_row = ({1'b0, row_r} + ROWS_W'(1)) >= rows_eff;

    grp_nxt   = grp_r;
    blk_nxt   = blk_r;
    row_nxt   = row_r;
    scale_nxt = scale_r;
    if (in_xfer) begin
      if (grp_r == '0) begin
        scale_nxt = in_scale;
      end
      if (blk_end) begin
        grp_nxt = '0;
        if (row_done) begin
          blk_nxt = '0;
          row_nxt = last_row ? '0 : row_r + ROW_IDX_W'(1);
        end else begin
          blk_nxt = blk_r + BLK_W'(1);
        end
      end else begin
        grp_nxt = grp_r + GRP_W'(1);
      end
    end

    tag0_nxt.valid     = in_xfer;
    tag0_nxt.blk_end   = blk_end;
    tag0_nxt.row_end   = blk_end && row_done;
    tag0_nxt.last      = last_row;
    tag0_nxt.row_index = row_r;
    tag0_nxt.scale     = (grp_r == '0) ? in_scale : scale_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grp_r   <= '0;
      blk_r   <= '0;
      row_r   <= '0;
      scale_r <= '0;
      tag0_r  <= '0;
    end else if (adv) begin
      grp_r   <= grp_nxt;
      blk_r   <= blk_nxt;
      row_r   <= row_nxt;
      scale_r <= scale_nxt;
      tag0_r  <= tag0_nxt;
    end
  end

  // ---------------- lanes ----------------
  logic signed [PROD_W-1:0] prod [LANES];

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    q8mv_lane u_lane (
      .clk    (clk),
      .en     (adv),
      .q_i    ($signed(in_tdata[g*Q_W +: Q_W])),
      .act_i  ($signed(in_tdata[LANES*Q_W + g*ACT_W +: ACT_W])),
      .prod_r (prod[g])
    );
  end

  // ---------------- merge and scale ----------------
  q8mv_tag_t                mg_tag;
  logic signed [BSUM_W-1:0] bsum;
  q8mv_tag_t                sc_tag;
  logic [ACC_W-1:0]         term;
  logic                     tsat;

  q8mv_merge #(.LANES(LANES)) u_merge (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_i  (tag0_r),
    .prod_i (prod),
    .tag_r  (mg_tag),
    .bsum_r (bsum)
  );

  q8mv_scale u_scale (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (adv),
    .tag_i  (mg_tag),
    .bsum_i (bsum),
    .tag_r  (sc_tag),
    .term_r (term),
    .tsat_r (tsat)
  );

  // ---------------- row accumulation and output register ----------------
  logic [ACC_W-1:0]     row_acc_r, row_acc_nxt;
  logic                 row_sat_r, row_sat_nxt;
  logic [ACC_W:0]       sum_wide;
  logic [ACC_W-1:0]     acc_new;
  logic                 sat_new;
  logic                 out_tvalid_r, out_tvalid_nxt;
  logic [ACC_W-1:0]     out_sum_r;
  logic [ROW_IDX_W-1:0] out_idx_r;
  logic                 out_last_r;
  logic                 out_sat_r;
  logic                 emit;

  // hold everything while a row result waits behind a full output register
  assign adv  = !(sc_tag.valid && sc_tag.row_end && out_tvalid_r && !out_tready);
  assign emit = adv && sc_tag.valid && sc_tag.row_end;

  always_comb begin
    sum_wide = {row_acc_r[ACC_W-1], row_acc_r} + {term[ACC_W-1], term};
    sat_new  = row_sat_r || tsat;
    if (sum_wide[ACC_W] != sum_wide[ACC_W-1]) begin
      acc_new = sum_wide[ACC_W] ? ACC_MIN : ACC_MAX;
      sat_new = 1'b1;
    end else begin
      acc_new = sum_wide[ACC_W-1:0];
    end

    row_acc_nxt = row_acc_r;
    row_sat_nxt = row_sat_r;
    if (adv && sc_tag.valid) begin
      row_acc_nxt = sc_tag.row_end ? '0 : acc_new;
      row_sat_nxt = sc_tag.row_end ? 1'b0 : sat_new;
    end

    out_tvalid_nxt = out_tvalid_r;
    if (emit) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_acc_r    <= '0;
      row_sat_r    <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      row_acc_r    <= row_acc_nxt;
      row_sat_r    <= row_sat_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_sum_r  <= acc_new;
      out_idx_r  <= sc_tag.row_index;
      out_last_r <= sc_tag.last;
      out_sat_r  <= sat_new;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {out_idx_r, out_sum_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_sat_r;

endmodule

[rtl/core/q8mv_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_checker
// Port-level checks on the mat-vec core, bound to the top level.
// ----------------------------------------------------------------------------
module q8mv_checker import q8mv_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast,
  input logic                   out_tuser
);

  // a pending result is not withdrawn
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  // a pending result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("output payload changed while stalled");

  // the input stalls only behind a blocked output
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without a blocked output");

  // reset empties the output register and opens the input
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("state not cleared by reset");

endmodule

bind q8_block_quantized_matvec q8mv_checker u_q8mv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

[verif/q8mv_row_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q8mv_row_checker
// Passive checker for the Q8_0 mat-vec core. It follows every input and
// register transfer, and from them works out each row result: the lane dot
// products, the block sum scaled by the half-float and the saturating row
// accumulator. Each output transfer is compared field by field with the
// oldest predicted row.
// ----------------------------------------------------------------------------
module q8mv_row_checker import q8mv_pkg::*; #(
  parameter int BLOCK_SIZE = BLOCK_SIZE_DEF,
  parameter int LANES      = LANES_DEF,
  parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
  parameter int IN_W       = ((LANES_DEF * (Q_W + ACT_W) + SCALE_W + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_W-1:0]        in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic                   out_tuser,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     mismatches,
  output int                     rows_due
);

  localparam int     GROUPS     = BLOCK_SIZE / LANES;
  localparam longint ROW_TOP    = (64'sd1 <<< (ACC_W - 1)) - 64'sd1;
  localparam longint ROW_BOTTOM = -(64'sd1 <<< (ACC_W - 1));

  typedef struct packed {
    logic [ACC_W-1:0]     row_sum;
    logic [ROW_IDX_W-1:0] row_index;
    logic                 last_row;
    logic                 saturated;
  } row_result_t;

  logic [BPR_W-1:0]   blocks_reg;
  logic [ROWS_W-1:0]  rows_reg;
  int unsigned        group_idx;
  int unsigned        block_idx;
  int unsigned        row_idx;
  longint             block_sum;
  longint             row_acc;
  logic [SCALE_W-1:0] held_scale;
  bit                 row_clipped;
  row_result_t        pending_rows[$];
  row_result_t        oldest;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s mismatch, got %h, expected %h", $time, field, got, want);
    mismatches++;
  endtask

  // block sum (12 fraction bits) times half-float scale, to 24 fraction bits
  task automatic scale_block_sum(input longint bsum, input logic [SCALE_W-1:0] h,
                                 output longint term, output bit clipped);
    bit                    neg;
    longint unsigned       mag;
    longint unsigned       prod;
    longint unsigned       lim;
    logic [HALF_EXP_W-1:0] ex;
    int                    sh;
    neg = (bsum < 0) ^ h[SCALE_W-1];
    mag = (bsum < 0) ? -bsum : bsum;
    ex  = h[HALF_FRAC_W +: HALF_EXP_W];
    lim = neg ? (64'd1 << (ACC_W - 1)) : (64'd1 << (ACC_W - 1)) - 64'd1;
    clipped = 1'b0;
    if (ex == HALF_EXP_INF) begin
      clipped = 1'b1;
      term = (mag == 0) ? 64'sd0 : (neg ? ROW_BOTTOM : ROW_TOP);
    end else begin
      prod = mag * {ex != 0, h[HALF_FRAC_W-1:0]};
      // subnormals use the exponent of the smallest normal
      sh = ((ex != 0) ? int'(ex) : 1) - int'(EXP_UNITY);
      if (sh < 0) begin
        // round half away from zero on the magnitude
        prod = (prod + (64'd1 << (-sh - 1))) >> (-sh);
      end else if (sh > 0) begin
        if (prod > (lim >> sh)) begin
          prod    = lim;
          clipped = 1'b1;
        end else begin
          prod = prod << sh;
        end
      end
      term = neg ? -$signed(prod) : $signed(prod);
    end
  endtask

  task automatic fold_item(input logic [IN_W-1:0] d);
    longint      lane_dot;
    longint      wgt;
    longint      act;
    longint      term;
    longint      next_acc;
    bit          clip;
    int unsigned blocks_eff;
    int unsigned rows_eff;
    int          i;
    row_result_t r;
    lane_dot = 0;
    if (group_idx == 0)
      held_scale = d[LANES*(Q_W+ACT_W) +: SCALE_W];
    for (i = 0; i < LANES; i++) begin
      wgt = longint'($signed(d[i*Q_W +: Q_W]));
      act = longint'($signed(d[LANES*Q_W + i*ACT_W +: ACT_W]));
      lane_dot += wgt * act;
    end
    block_sum += lane_dot;
    if (group_idx + 1 < GROUPS) begin
      group_idx++;
      return;
    end
    group_idx = 0;

    scale_block_sum(block_sum, held_scale, term, clip);
    block_sum = 0;
    next_acc = row_acc + term;
    if (next_acc > ROW_TOP) begin
      next_acc = ROW_TOP;
      clip     = 1'b1;
    end
    if (next_acc < ROW_BOTTOM) begin
      next_acc = ROW_BOTTOM;
      clip     = 1'b1;
    end
    row_acc     = next_acc;
    row_clipped = row_clipped | clip;

    // out-of-range register values are clamped; a count already past the
    // limit ends the row at once
    blocks_eff = (blocks_reg == 0) ? 1 : ((blocks_reg > MAX_BLOCKS) ? MAX_BLOCKS : blocks_reg);
    if (block_idx + 1 < blocks_eff) begin
      block_idx++;
      return;
    end
    block_idx = 0;

    rows_eff = (rows_reg == 0) ? 1 : ((rows_reg > MAX_ROWS) ? MAX_ROWS : rows_reg);
    r.row_sum   = row_acc[ACC_W-1:0];
    r.row_index = row_idx[ROW_IDX_W-1:0];
    r.saturated = row_clipped;
    r.last_row  = (row_idx + 1 >= rows_eff);
    row_idx     = r.last_row ? 0 : row_idx + 1;
    pending_rows.push_back(r);
    rows_due    = pending_rows.size();
    row_acc     = 0;
    row_clipped = 1'b0;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      blocks_reg  = BPR_W'(1);
      rows_reg    = ROWS_W'(1);
      group_idx   = 0;
      block_idx   = 0;
      row_idx     = 0;
      block_sum   = 0;
      row_acc     = 0;
      held_scale  = '0;
      row_clipped = 1'b0;
      pending_rows.delete();
      rows_due    = 0;
      mismatches  = 0;
    end else begin
      // results first: nothing accepted at this edge may already be out
      if (out_tvalid && out_tready) begin
        if (pending_rows.size() == 0) begin
          report_mismatch("unexpected row", out_tdata, '0);
        end else begin
          oldest   = pending_rows.pop_front();
          rows_due = pending_rows.size();
          if (out_tdata[ACC_W-1:0] !== oldest.row_sum)
            report_mismatch("row_sum", out_tdata[ACC_W-1:0], oldest.row_sum);
          if (out_tdata[ACC_W +: ROW_IDX_W] !== oldest.row_index)
            report_mismatch("row_index", out_tdata[ACC_W +: ROW_IDX_W], oldest.row_index);
          if (out_tlast !== oldest.last_row)
            report_mismatch("last_row", out_tlast, oldest.last_row);
          if (out_tuser !== oldest.saturated)
            report_mismatch("saturated", out_tuser, oldest.saturated);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLOCKS_PER_ROW: blocks_reg = cfg_data[BPR_W-1:0];
          CFG_ROW_COUNT:      rows_reg   = cfg_data[ROWS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        fold_item(in_tdata);
    end
  end

endmodule

[verif/tb_q8_block_quantized_matvec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q8_block_quantized_matvec
// Stimulus for the Q8_0 mat-vec core: saturating and NaN/Inf scale blocks,
// accumulator overflow, then random rows over a range of matrix shapes,
// with random gaps on both channels and a long output hold. Checking is
// done by q8mv_row_checker.
// ----------------------------------------------------------------------------
module tb_q8_block_quantized_matvec;
  import q8mv_pkg::*;

  localparam int IN_W            = ((LANES_DEF * (Q_W + ACT_W) + SCALE_W + 7) / 8) * 8;
  localparam int ITEMS_PER_BLOCK = BLOCK_SIZE_DEF / LANES_DEF;
  localparam int GAP_MAX         = 18;
  localparam int SETTLE_CYCLES   = 10;   // margin for the pipe to empty
  localparam int HOLD_CYCLES     = 400;
  localparam int CYCLE_LIMIT     = 400000;

  localparam logic [SCALE_W-1:0] HALF_POS_INF  = 16'h7C00;
  localparam logic [SCALE_W-1:0] HALF_NEG_NAN  = 16'hFE00;
  localparam logic [SCALE_W-1:0] HALF_NAN      = 16'h7C01;
  localparam logic [SCALE_W-1:0] HALF_NEAR_TOP = 16'h5BFF;  // largest term that fits

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_W-1:0]        in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic                   out_tuser;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  int mismatches;
  int rows_due;
  int rx_hold     = 0;
  bit tx_gapless  = 1'b0;
  bit rx_gapless  = 1'b0;
  int cycle_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  q8_block_quantized_matvec uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  q8mv_row_checker #(.IN_W(IN_W)) row_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .rows_due   (rows_due)
  );

  // mostly moderate exponents so rows stay in range; the rest hit the edges
  function automatic logic [SCALE_W-1:0] pick_scale();
    int unsigned           pick;
    logic [31:0]           raw;
    logic [HALF_EXP_W-1:0] ex;
    pick = $urandom_range(0, 19);
    raw  = $urandom;
    if (pick < 11)
      ex = HALF_EXP_W'($urandom_range(6, 18));
    else if (pick < 14)
      ex = '0;
    else if (pick < 17)
      ex = HALF_EXP_W'($urandom_range(19, 30));
    else if (pick < 18)
      ex = HALF_EXP_INF;
    else
      return raw[SCALE_W-1:0];
    return {raw[15], ex, raw[HALF_FRAC_W-1:0]};
  endfunction

  task automatic offer_item(input logic [IN_W-1:0] d);
    int gap;
    gap = tx_gapless ? 0 : $urandom_range(0, GAP_MAX);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic offer_lanes(input logic [LANES_DEF*Q_W-1:0] qv,
                             input logic [LANES_DEF*ACT_W-1:0] av,
                             input logic [SCALE_W-1:0] sc);
    logic [IN_W-1:0] d;
    d = '0;
    d[LANES_DEF*Q_W-1:0]                     = qv;
    d[LANES_DEF*Q_W +: LANES_DEF*ACT_W]      = av;
    d[LANES_DEF*(Q_W+ACT_W) +: SCALE_W]      = sc;
    offer_item(d);
  endtask

  // one block with the same weight and activation in every lane
  task automatic offer_const_block(input logic [Q_W-1:0] q, input logic [ACT_W-1:0] a,
                                   input logic [SCALE_W-1:0] sc);
    int k;
    for (k = 0; k < ITEMS_PER_BLOCK; k++)
      offer_lanes({LANES_DEF{q}}, {LANES_DEF{a}}, (k == 0) ? sc : pick_scale());
  endtask

  task automatic offer_random_items(input int n);
    logic [LANES_DEF*Q_W-1:0]   qv;
    logic [LANES_DEF*ACT_W-1:0] av;
    int                         i;
    int                         k;
    for (k = 0; k < n; k++) begin
      for (i = 0; i < LANES_DEF; i++) begin
        qv[i*Q_W +: Q_W]     = Q_W'($urandom);
        av[i*ACT_W +: ACT_W] = ACT_W'($urandom);
      end
      offer_lanes(qv, av, pick_scale());
    end
  endtask

  // both registers back to back; valid stays high between the two transfers
  task automatic program_shape(input logic [CFG_DATA_W-1:0] blocks,
                               input logic [CFG_DATA_W-1:0] rows);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_BLOCKS_PER_ROW;
    cfg_data  <= blocks;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_ROW_COUNT;
    cfg_data  <= rows;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // stop offering, wait for every predicted row, then let the pipe empty
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (rows_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: random stall per row, or one long hold on request
  initial begin
    int stall;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = rx_gapless ? 0 : $urandom_range(0, GAP_MAX);
      end
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid && rx_hold == 0) @(posedge clk);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("q8_block_quantized_matvec regression: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset shape: each block is a whole one-row matrix
    offer_const_block(8'h7F, 16'h7FFF, HALF_POS_INF);   // Inf scale, positive extreme
    offer_const_block(8'h80, 16'h8000, HALF_NEG_NAN);   // NaN with sign: negative extreme
    offer_const_block(8'h00, 16'h8000, HALF_NAN);       // NaN on a zero sum gives zero
    offer_random_items(40);
    settle();

    // two near-full terms overflow the row accumulator
    program_shape(2, 3);
    offer_const_block(8'h7F, 16'h7FFF, HALF_NEAR_TOP);
    offer_const_block(8'h7F, 16'h7FFF, HALF_NEAR_TOP);
    offer_random_items(100);
    settle();

    // zero registers act as one; written part way through a row
    program_shape(0, 0);
    tx_gapless = 1'b1;
    rx_gapless = 1'b1;
    offer_random_items(60);
    settle();
    tx_gapless = 1'b0;
    rx_gapless = 1'b0;

    program_shape(3, 4);
    offer_random_items(150);
    settle();

    // hold the output off while the sender streams, so the input backs up
    program_shape(1, 7);
    rx_hold    = HOLD_CYCLES;
    tx_gapless = 1'b1;
    offer_random_items(200);
    tx_gapless = 1'b0;
    settle();

    // row count above range clamps to 65536
    program_shape(5, 32'hFFFF_FFFF);
    offer_random_items(153);
    settle();

    // row counter already past the new count: next row is the last
    program_shape(2, 2);
    offer_random_items(120);
    settle();

    // blocks per row above range: the row stays open into the next shape,
    // whose smaller count then ends it at the next block
    program_shape(32'hFFFF_FFFF, 32'h0001_0000);
    offer_random_items(40);
    settle();

    program_shape(4, 3);
    tx_gapless = 1'b1;
    rx_gapless = 1'b1;
    offer_random_items(150);
    settle();

    if (mismatches == 0)
      $display("q8_block_quantized_matvec regression: pass");
    else
      $display("q8_block_quantized_matvec regression: fail");
    $finish;
  end

endmodule
